/* rtl/lcs_pkg.sv */
// shared types, constants and helpers of the lcs length engine
package lcs_pkg;

  // reference capacity and derived widths
  localparam int MAX_LEN = 64;
  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CELL_W  = CNT_W;
  localparam int CH_W    = 8;
  localparam int LEN_W   = 7;
  localparam int LEN_MAX = (1 << LEN_W) - 1;

  // operation codes
  localparam logic OP_REF   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic            op;
    logic [CH_W-1:0] ch;
    logic            last;
  } item_t;

  typedef struct packed {
    logic [LEN_W-1:0] lcs_length;
    logic             ref_truncated;
  } result_t;

  // clamp a row cell to the width of the reported length
  function automatic logic [LEN_W-1:0] sat_len(input logic [CELL_W-1:0] v);
    logic [31:0] wide;
    wide = 32'(v);
    if (wide > 32'(LEN_MAX)) begin
      return LEN_W'(LEN_MAX);
    end
    return LEN_W'(wide);
  endfunction

endpackage

/* rtl/lcs_length_engine_unit.sv */
// top level of the lcs length engine: reference store, row sweep and result
//
// Usage: drive item and raise start; a beat is taken at a clock edge where
// start is high and busy is low. A reference character (op 0) is stored and
// busy stays low. A query character (op 1) sweeps the dynamic programming
// row: the row memory is read, updated and written back one cell per cycle,
// with busy high until the sweep ends. The sweep rate is set by the single
// read and single write port of the row memory.
// On a query character marked last, the result beat (lcs_length and
// ref_truncated) is shown for exactly one cycle with done high, in the cycle
// after the sweep ends; the receiver cannot stall it. Other characters give
// no result beat. The next reference character after a finished query starts
// a new reference.
// Reset (rst, synchronous, active high) empties the reference, clears the
// truncation flag and marks all row cells as zero through per-cell valid
// bits; it takes effect without any clearing pass.
module lcs_length_engine_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  lcs_pkg::item_t    item,
  output logic              done,
  output lcs_pkg::result_t  result
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_SWEEP = 1'b1;

  logic                             state;
  logic [lcs_pkg::CNT_W-1:0]        ref_count;
  logic                             ref_complete;
  logic                             overflow_flag;
  logic [lcs_pkg::MAX_LEN-1:0]      dp_valid;

  logic [lcs_pkg::CH_W-1:0]         qch;
  logic                             qlast;
  logic [lcs_pkg::CNT_W-1:0]        rd_idx;
  logic                             rd_pend;
  logic [lcs_pkg::ADDR_W-1:0]       wr_idx;
  logic [lcs_pkg::CELL_W-1:0]       diag;
  logic [lcs_pkg::CELL_W-1:0]       left;

  logic                             accept;
  logic [lcs_pkg::CNT_W-1:0]        count_eff;
  logic                             ref_we;
  logic [lcs_pkg::CH_W-1:0]         ref_rdata;
  logic [lcs_pkg::CELL_W-1:0]       dp_rdata;
  logic [lcs_pkg::CELL_W-1:0]       up;
  logic [lcs_pkg::CELL_W-1:0]       cell_next;
  logic                             issue;
  logic                             sweep_end;

  assign busy   = (state == ST_SWEEP);
  assign accept = start && !busy;

  // effective count, restarting a finished reference
  assign count_eff = ref_complete ? '0 : ref_count;
  assign ref_we    = accept && (item.op == lcs_pkg::OP_REF) &&
                     (count_eff < lcs_pkg::CNT_W'(lcs_pkg::MAX_LEN));

  // sweep control
  assign issue     = (state == ST_SWEEP) && (rd_idx < ref_count);
  assign sweep_end = (state == ST_SWEEP) && !issue && !rd_pend;

  // cell update from the entry read in the previous cycle
  assign up = dp_valid[wr_idx] ? dp_rdata : '0;
  always_comb begin
    if (ref_rdata == qch) begin
      cell_next = lcs_pkg::CELL_W'(diag + 1'b1);
    end else if (left > up) begin
      cell_next = left;
    end else begin
      cell_next = up;
    end
  end

  // reference character store
  lcs_ram #(
    .WIDTH (lcs_pkg::CH_W),
    .DEPTH (lcs_pkg::MAX_LEN)
  ) u_ref_ram (
    .clk   (clk),
    .we    (ref_we),
    .waddr (count_eff[lcs_pkg::ADDR_W-1:0]),
    .wdata (item.ch),
    .raddr (rd_idx[lcs_pkg::ADDR_W-1:0]),
    .rdata (ref_rdata)
  );

  // dynamic programming row store
  lcs_ram #(
    .WIDTH (lcs_pkg::CELL_W),
    .DEPTH (lcs_pkg::MAX_LEN)
  ) u_dp_ram (
    .clk   (clk),
    .we    (rd_pend),
    .waddr (wr_idx),
    .wdata (cell_next),
    .raddr (rd_idx[lcs_pkg::ADDR_W-1:0]),
    .rdata (dp_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      ref_count     <= '0;
      ref_complete  <= 1'b1;
      overflow_flag <= 1'b0;
      dp_valid      <= '0;
      rd_pend       <= 1'b0;
      done          <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept && (item.op == lcs_pkg::OP_REF)) begin
            if (ref_complete) begin
              ref_complete  <= 1'b0;
              overflow_flag <= 1'b0;
              dp_valid      <= '0;
            end else if (ref_we) begin
              dp_valid[count_eff[lcs_pkg::ADDR_W-1:0]] <= 1'b0;
            end
            if (ref_we) begin
              ref_count <= lcs_pkg::CNT_W'(count_eff + 1'b1);
            end else begin
              ref_count     <= count_eff;
              overflow_flag <= 1'b1;
            end
          end else if (accept) begin
            state <= ST_SWEEP;
          end
        end
        ST_SWEEP: begin
          rd_pend <= issue;
          if (rd_pend) begin
            dp_valid[wr_idx] <= 1'b1;
          end
          if (sweep_end) begin
            state <= ST_IDLE;
            if (qlast) begin
              done         <= 1'b1;
              dp_valid     <= '0;
              ref_complete <= 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // sweep datapath and result payload
  always_ff @(posedge clk) begin
    if (accept && (item.op == lcs_pkg::OP_QUERY)) begin
      qch    <= item.ch;
      qlast  <= item.last;
      rd_idx <= '0;
      diag   <= '0;
      left   <= '0;
    end else begin
      if (issue) begin
        rd_idx <= lcs_pkg::CNT_W'(rd_idx + 1'b1);
        wr_idx <= rd_idx[lcs_pkg::ADDR_W-1:0];
      end
      if (rd_pend) begin
        diag <= up;
        left <= cell_next;
      end
    end
    if (sweep_end) begin
      result.lcs_length    <= lcs_pkg::sat_len(left);
      result.ref_truncated <= overflow_flag;
    end
  end

  // checks
  a_done_after_sweep: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == ST_SWEEP)
    else $error("result beat without a finished sweep");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    ref_count <= lcs_pkg::CNT_W'(lcs_pkg::MAX_LEN))
    else $error("reference count beyond capacity");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SWEEP |-> rd_idx <= ref_count)
    else $error("row read past the stored reference");

  a_pend_in_sweep: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> state == ST_SWEEP)
    else $error("row write back outside a sweep");

endmodule

/* rtl/lcs_ram.sv */
// generic single-write, single-read ram with registered read data
module lcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* dv/tb.sv */
// self-checking testbench for the lcs length engine: random bursts of beats against a predictor
module tb;

  typedef struct {
    lcs_pkg::item_t beat;
    bit             drain;
  } pend_t;

  logic             clk;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  lcs_pkg::item_t   item = '0;
  logic             busy;
  logic             done;
  lcs_pkg::result_t result;

  pend_t            pend_q[$];
  lcs_pkg::result_t length_q[$];
  int unsigned      beats_total;
  int unsigned      beats_taken;
  int unsigned      mismatch_cnt;
  int               burst_left;
  int               gap_left;

  // predictor copy of the reference store and the dp row
  logic [lcs_pkg::CH_W-1:0] ref_chars [lcs_pkg::MAX_LEN];
  int                       lcs_row [lcs_pkg::MAX_LEN];
  int                       ref_len;
  bit                       ref_closed;
  bit                       ref_over;

  lcs_pkg::result_t want;
  lcs_pkg::result_t next_len;
  bit               emits;

  lcs_length_engine_unit uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // expected lcs length after one beat, if the beat closes a query
  function automatic void lcs_predict(input lcs_pkg::item_t beat, output bit has_len,
                                      output lcs_pkg::result_t res);
    int diag;
    int left;
    int up;
    int cell_val;
    int len;
    has_len = 1'b0;
    res = '0;
    if (beat.op == lcs_pkg::OP_REF) begin
      // first reference character after a finished query starts afresh
      if (ref_closed) begin
        ref_len = 0;
        ref_over = 1'b0;
        ref_closed = 1'b0;
        foreach (lcs_row[j]) lcs_row[j] = 0;
      end
      if (ref_len < lcs_pkg::MAX_LEN) begin
        ref_chars[ref_len] = beat.ch;
        lcs_row[ref_len] = 0;
        ref_len++;
      end else begin
        ref_over = 1'b1;
      end
    end else begin
      // one row of the dp table, swept left to right
      diag = 0;
      left = 0;
      for (int j = 0; j < ref_len; j++) begin
        up = lcs_row[j];
        if (ref_chars[j] == beat.ch) cell_val = diag + 1;
        else cell_val = (left > up) ? left : up;
        diag = up;
        lcs_row[j] = cell_val;
        left = cell_val;
      end
      if (beat.last) begin
        len = (ref_len > 0) ? lcs_row[ref_len-1] : 0;
        if (len > lcs_pkg::LEN_MAX) len = lcs_pkg::LEN_MAX;
        res.lcs_length = lcs_pkg::LEN_W'(len);
        res.ref_truncated = ref_over;
        has_len = 1'b1;
        foreach (lcs_row[j]) lcs_row[j] = 0;
        ref_closed = 1'b1;
      end
    end
  endfunction

  function automatic void add_beat(input logic op, input logic [lcs_pkg::CH_W-1:0] ch,
                                   input logic last, input bit drain = 1'b0);
    pend_t p;
    p.beat.op = op;
    p.beat.ch = ch;
    p.beat.last = last;
    p.drain = drain;
    pend_q.push_back(p);
  endfunction

  // narrow picks stay near a base byte so that matches are common
  function automatic logic [lcs_pkg::CH_W-1:0] pick_char(
      input bit narrow, input logic [lcs_pkg::CH_W-1:0] base);
    if (narrow) return base + lcs_pkg::CH_W'($urandom_range(0, 3));
    return lcs_pkg::CH_W'($urandom);
  endfunction

  // driver: bursts of beats with random gaps, draining beats wait for an idle block
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!start || !busy) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pend_q.size() != 0 &&
                   !(pend_q[0].drain &&
                     (start || busy || done || length_q.size() != 0))) begin
        item <= pend_q[0].beat;
        start <= 1'b1;
        pend_q.pop_front();
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 30);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: check result beats, predict on every accepted beat
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (length_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("result beat with nothing expected: len %0d trunc %0b",
                     result.lcs_length, result.ref_truncated);
        end else begin
          want = length_q.pop_front();
          if (result.lcs_length !== want.lcs_length ||
              result.ref_truncated !== want.ref_truncated) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("mismatch: expected len %0d trunc %0b, got len %0d trunc %0b",
                       want.lcs_length, want.ref_truncated,
                       result.lcs_length, result.ref_truncated);
          end
        end
      end
      if (start && !busy) begin
        beats_taken++;
        lcs_predict(item, emits, next_len);
        if (emits) length_q.push_back(next_len);
      end
    end
  end

  initial begin : stimulus
    logic [lcs_pkg::CH_W-1:0] base;
    logic [lcs_pkg::CH_W-1:0] word [lcs_pkg::MAX_LEN];
    bit                       narrow;
    int                       kind;
    int                       rlen;
    int                       nq;
    int                       qlen;
    int                       seq;

    ref_len = 0;
    ref_closed = 1'b1;
    ref_over = 1'b0;
    foreach (lcs_row[j]) lcs_row[j] = 0;
    foreach (ref_chars[j]) ref_chars[j] = '0;

    // directed: query on empty reference
    add_beat(lcs_pkg::OP_QUERY, 8'hFF, 1'b1);
    // last flag on a reference character is ignored; byte extremes
    add_beat(lcs_pkg::OP_REF, 8'h00, 1'b1);
    add_beat(lcs_pkg::OP_REF, 8'hFF, 1'b0);
    add_beat(lcs_pkg::OP_REF, 8'h5A, 1'b0);
    add_beat(lcs_pkg::OP_QUERY, 8'hFF, 1'b0);
    // reference character slipped into a running query
    add_beat(lcs_pkg::OP_REF, 8'h81, 1'b0);
    add_beat(lcs_pkg::OP_QUERY, 8'h81, 1'b1);
    // second query against the same reference
    add_beat(lcs_pkg::OP_QUERY, 8'h00, 1'b0);
    add_beat(lcs_pkg::OP_QUERY, 8'h5A, 1'b0);
    add_beat(lcs_pkg::OP_QUERY, 8'h00, 1'b1);
    // restart with a fresh reference, no match
    add_beat(lcs_pkg::OP_REF, 8'h12, 1'b0);
    add_beat(lcs_pkg::OP_QUERY, 8'h34, 1'b1);
    add_beat(lcs_pkg::OP_REF, 8'hA5, 1'b0);
    add_beat(lcs_pkg::OP_REF, 8'h5A, 1'b1);
    add_beat(lcs_pkg::OP_QUERY, 8'h5A, 1'b0);
    add_beat(lcs_pkg::OP_QUERY, 8'hA5, 1'b1);

    // random sequences, the first two aimed at full length and overflow
    seq = 0;
    while (pend_q.size() < 1000) begin
      kind = $urandom_range(0, 9);
      narrow = $urandom_range(0, 1);
      base = lcs_pkg::CH_W'($urandom);
      if (seq == 0) begin
        // full reference matched by an identical query
        for (int k = 0; k < lcs_pkg::MAX_LEN; k++) begin
          word[k] = lcs_pkg::CH_W'($urandom);
          add_beat(lcs_pkg::OP_REF, word[k], 1'b0, k == 0);
        end
        for (int k = 0; k < lcs_pkg::MAX_LEN; k++)
          add_beat(lcs_pkg::OP_QUERY, word[k], k == lcs_pkg::MAX_LEN - 1);
      end else if (seq == 1) begin
        // reference longer than the store
        for (int k = 0; k < lcs_pkg::MAX_LEN + 6; k++)
          add_beat(lcs_pkg::OP_REF, pick_char(narrow, base),
                   1'(($urandom_range(0, 7) == 0)));
        for (int k = 0; k < 5; k++)
          add_beat(lcs_pkg::OP_QUERY, pick_char(narrow, base), k == 4);
      end else if (kind < 8) begin
        // well-formed: reference then a few queries
        rlen = ($urandom_range(0, 9) == 0) ? $urandom_range(13, lcs_pkg::MAX_LEN + 3)
                                           : $urandom_range(1, 12);
        for (int k = 0; k < rlen; k++)
          add_beat(lcs_pkg::OP_REF, pick_char(narrow, base), 1'($urandom_range(0, 1)),
                   k == 0 && $urandom_range(0, 7) == 0);
        nq = $urandom_range(1, 3);
        for (int q = 0; q < nq; q++) begin
          qlen = $urandom_range(1, 10);
          for (int k = 0; k < qlen; k++) begin
            if ($urandom_range(0, 19) == 0)
              add_beat(lcs_pkg::OP_REF, pick_char(narrow, base), 1'b0);
            add_beat(lcs_pkg::OP_QUERY, pick_char(narrow, base), k == qlen - 1);
          end
        end
      end else begin
        // noise: any field values
        rlen = $urandom_range(1, 4);
        for (int k = 0; k < rlen; k++)
          add_beat(1'($urandom), lcs_pkg::CH_W'($urandom), 1'($urandom));
      end
      seq++;
    end
    beats_total = pend_q.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (beats_taken != beats_total || length_q.size() != 0) @(posedge clk);
    // wait out the longest sweep and its result beat
    repeat (100) @(posedge clk);
    if (mismatch_cnt == 0 && length_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("tb failed");
    $finish;
  end

endmodule
